### rtl/core/ptts_pkg.sv
package ptts_pkg;

  localparam int SLOTS_DEF       = 8;
  localparam int PERIOD_BITS_DEF = 16;
  localparam int IN_PERIOD_W     = 16;
  localparam int SLOT_W          = 3;

  typedef enum logic [1:0] {
    KIND_REG  = 2'd0,
    KIND_TICK = 2'd1,
    KIND_RUN  = 2'd2,
    KIND_NONE = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_FULL     = 2'd1,
    STAT_DISABLED = 2'd2
  } status_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_PASS = 1'b1
  } state_t;

  typedef struct packed {
    logic [1:0]             kind;
    logic [IN_PERIOD_W-1:0] period;
  } in_item_t;

  typedef struct packed {
    logic [1:0]        done_kind;
    logic [1:0]        status;
    logic [SLOT_W-1:0] slot;
    logic              dispatched;
    logic              last;
  } out_item_t;

  typedef struct packed {
    logic used;
    logic ready;
  } slot_flags_t;

  // Pass context handed from the sequencer to the head stage.
  typedef struct packed {
    logic [1:0]        op;
    logic              run_en;
    logic              claimed;
    logic              last_step;
    logic              any_ready;
    logic              more_ready;
    logic [SLOT_W-1:0] slot;
  } head_ctl_t;

  typedef struct packed {
    logic      emit;
    logic      claim;
    out_item_t item;
  } head_res_t;

endpackage

### rtl/core/ptts_cell.sv
module ptts_cell
  import ptts_pkg::*;
#(
  parameter int PERIOD_BITS = PERIOD_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   shift,
  input  slot_flags_t            flags_in,
  input  logic [PERIOD_BITS-1:0] period_in,
  input  logic [PERIOD_BITS-1:0] cd_in,
  output slot_flags_t            flags_o,
  output logic [PERIOD_BITS-1:0] period_o,
  output logic [PERIOD_BITS-1:0] cd_o
);

  slot_flags_t            flags_r;
  logic [PERIOD_BITS-1:0] period_r;
  logic [PERIOD_BITS-1:0] cd_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flags_r <= '0;
    end else if (shift) begin
      flags_r <= flags_in;
    end
  end

  // Payload carries no reset: only used slots are ever read.
  always_ff @(posedge clk) begin
    if (shift) begin
      period_r <= period_in;
      cd_r     <= cd_in;
    end
  end

  assign flags_o  = flags_r;
  assign period_o = period_r;
  assign cd_o     = cd_r;

endmodule

### rtl/core/ptts_head.sv
module ptts_head
  import ptts_pkg::*;
#(
  parameter int PERIOD_BITS = PERIOD_BITS_DEF
) (
  input  head_ctl_t              ctl,
  input  logic [PERIOD_BITS-1:0] new_period,
  input  slot_flags_t            flags_in,
  input  logic [PERIOD_BITS-1:0] period_in,
  input  logic [PERIOD_BITS-1:0] cd_in,
  output slot_flags_t            flags_o,
  output logic [PERIOD_BITS-1:0] period_o,
  output logic [PERIOD_BITS-1:0] cd_o,
  output head_res_t              res
);

  always_comb begin
    flags_o  = flags_in;
    period_o = period_in;
    cd_o     = cd_in;
    res      = '0;
    res.item.done_kind = ctl.op;
    res.item.status    = STAT_OK;
    res.item.last      = 1'b1;

    case (ctl.op)
      KIND_REG: begin
        if (!ctl.claimed && !flags_in.used) begin
          flags_o.used  = 1'b1;
          flags_o.ready = 1'b0;
          period_o      = new_period;
          cd_o          = new_period;
          res.emit      = 1'b1;
          res.claim     = 1'b1;
          res.item.slot = ctl.slot;
        end else if (!ctl.claimed && ctl.last_step) begin
          res.emit        = 1'b1;
          res.item.status = STAT_FULL;
        end
      end
      KIND_TICK: begin
        if (flags_in.used && (cd_in != '0)) begin
          cd_o = cd_in - 1'b1;
          if (cd_in == PERIOD_BITS'(1)) begin
            flags_o.ready = 1'b1;
          end
        end
      end
      KIND_RUN: begin
        if (!ctl.run_en) begin
          if (ctl.last_step) begin
            res.emit        = 1'b1;
            res.item.status = STAT_DISABLED;
          end
        end else if (flags_in.used && flags_in.ready) begin
          cd_o                = period_in;
          flags_o.ready       = 1'b0;
          res.emit            = 1'b1;
          res.item.slot       = ctl.slot;
          res.item.dispatched = 1'b1;
          res.item.last       = !ctl.more_ready;
        end else if (ctl.last_step && !ctl.any_ready) begin
          res.emit = 1'b1;
        end
      end
      default: begin
        res.emit = 1'b0;
      end
    endcase
  end

endmodule

### rtl/core/periodic_task_tick_scheduler.sv
// Channel | Direction | Ports                          | Beat
// --------+-----------+--------------------------------+---------------------------------
// in      | input     | in_valid, in_stall, in_item    | one command: register/tick/run
// out     | output    | out_valid, out_stall, out_item | one result
// cfg     | input     | cfg_wr_en, cfg_wr_data         | run_enable write, no read-back
//
// Each command turns the slot ring once through the head stage (one slot per cycle
// while the result register takes results), then returns to idle to take the next beat.
// A command of the unused kind is dropped without starting a pass.
// A stalled result register freezes the ring until the result can be loaded.
// Reset is synchronous and active low; it clears all used/ready flags and sets
// run_enable. No clearing pass is needed.
module periodic_task_tick_scheduler
  import ptts_pkg::*;
#(
  parameter int SLOTS       = SLOTS_DEF,
  parameter int PERIOD_BITS = PERIOD_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_item,
  input  logic      cfg_wr_en,
  input  logic      cfg_wr_data
);

  localparam int STEP_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  // Ring of slot cells; cell 0 sits at the head stage.
  slot_flags_t            flags_q   [SLOTS];
  logic [PERIOD_BITS-1:0] period_q  [SLOTS];
  logic [PERIOD_BITS-1:0] cd_q      [SLOTS];
  slot_flags_t            flags_in  [SLOTS];
  logic [PERIOD_BITS-1:0] period_in [SLOTS];
  logic [PERIOD_BITS-1:0] cd_in     [SLOTS];

  slot_flags_t            head_flags;
  logic [PERIOD_BITS-1:0] head_period;
  logic [PERIOD_BITS-1:0] head_cd;
  head_ctl_t              head_ctl;
  head_res_t              head_res;

  state_t                 state_r, state_nxt;
  logic [1:0]             op_r;
  logic [PERIOD_BITS-1:0] new_period_r;
  logic [STEP_W-1:0]      step_r;
  logic [SLOTS-1:0]       mask_r;
  logic                   any_r;
  logic                   claimed_r;
  logic                   run_enable_r;
  logic                   out_valid_r;
  out_item_t              out_item_r;

  logic [SLOTS-1:0]       ready_snap;
  logic                   accept;
  logic                   can_emit;
  logic                   advance;
  logic                   last_step;

  // Build the ready snapshot with every slot at its home position.
  always_comb begin
    for (int k = 0; k < SLOTS; k++) begin
      ready_snap[k] = flags_q[k].used & flags_q[k].ready;
    end
  end

  // Hand each cell the contents of its neighbor; the tail takes the head result.
  always_comb begin
    for (int k = 0; k < SLOTS - 1; k++) begin
      flags_in[k]  = flags_q[k+1];
      period_in[k] = period_q[k+1];
      cd_in[k]     = cd_q[k+1];
    end
    flags_in[SLOTS-1]  = head_flags;
    period_in[SLOTS-1] = head_period;
    cd_in[SLOTS-1]     = head_cd;
  end

  for (genvar g = 0; g < SLOTS; g++) begin : g_cell
    ptts_cell #(
      .PERIOD_BITS(PERIOD_BITS)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .shift    (advance),
      .flags_in (flags_in[g]),
      .period_in(period_in[g]),
      .cd_in    (cd_in[g]),
      .flags_o  (flags_q[g]),
      .period_o (period_q[g]),
      .cd_o     (cd_q[g])
    );
  end

  assign last_step = (step_r == STEP_W'(SLOTS - 1));

  always_comb begin
    head_ctl            = '0;
    head_ctl.op         = op_r;
    head_ctl.run_en     = run_enable_r;
    head_ctl.claimed    = claimed_r;
    head_ctl.last_step  = last_step;
    head_ctl.any_ready  = any_r;
    head_ctl.more_ready = ((mask_r >> 1) != '0);
    head_ctl.slot       = SLOT_W'(step_r);
  end

  ptts_head #(
    .PERIOD_BITS(PERIOD_BITS)
  ) u_head (
    .ctl       (head_ctl),
    .new_period(new_period_r),
    .flags_in  (flags_q[0]),
    .period_in (period_q[0]),
    .cd_in     (cd_q[0]),
    .flags_o   (head_flags),
    .period_o  (head_period),
    .cd_o      (head_cd),
    .res       (head_res)
  );

  // Hold the ring while a result is due and the result register cannot take it.
  assign can_emit = !out_valid_r || !out_stall;
  assign advance  = (state_r == ST_PASS) && (!head_res.emit || can_emit);
  assign accept   = in_valid && !in_stall;
  assign in_stall = (state_r != ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept && (in_item.kind != KIND_NONE)) begin
          state_nxt = ST_PASS;
        end
      end
      ST_PASS: begin
        if (advance && last_step) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Pass context: step counter, claim flag, shifting ready mask.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r    <= '0;
      claimed_r <= 1'b0;
      mask_r    <= '0;
      any_r     <= 1'b0;
      op_r      <= KIND_NONE;
    end else if (accept) begin
      step_r    <= '0;
      claimed_r <= 1'b0;
      mask_r    <= ready_snap;
      any_r     <= (ready_snap != '0);
      op_r      <= in_item.kind;
    end else if (advance) begin
      step_r    <= last_step ? '0 : step_r + 1'b1;
      claimed_r <= claimed_r | head_res.claim;
      mask_r    <= mask_r >> 1;
    end
  end

  // Keep only the low PERIOD_BITS bits of the period (zero-extend if wider).
  always_ff @(posedge clk) begin
    if (accept) begin
      new_period_r <= PERIOD_BITS'(in_item.period);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_enable_r <= 1'b1;
    end else if (cfg_wr_en) begin
      run_enable_r <= cfg_wr_data;
    end
  end

  // Result register: load on emit, drop once the beat is taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance && head_res.emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && head_res.emit) begin
      out_item_r <= head_res.item;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

### tb/periodic_task_tick_scheduler_tb.sv
`timescale 1ns / 100ps

module periodic_task_tick_scheduler_tb
  import ptts_pkg::*;
();

  // Idle cycles with no beat on either channel and no config write before
  // the run is declared hung. This is far above any correct run, including
  // the sender gaps and the drain pause.
  localparam int IDLE_LIMIT   = 2000;
  // Cycles a tick may still be in the ring after the last result has left.
  localparam int SETTLE_CYCLES = 2 * (SLOTS_DEF + 1);

  // Task table predictor: mirrors the slot table and the run_enable register,
  // queues the results every accepted command should produce and checks each
  // result beat against the oldest one.
  class dispatch_predictor;
    bit                       used      [SLOTS_DEF];
    bit                       ready     [SLOTS_DEF];
    bit [PERIOD_BITS_DEF-1:0] reload    [SLOTS_DEF];
    bit [PERIOD_BITS_DEF-1:0] countdown [SLOTS_DEF];
    bit                       run_en;
    out_item_t                due_results[$];
    int                       mismatches;

    function new();
      for (int i = 0; i < SLOTS_DEF; i++) begin
        used[i]      = 1'b0;
        ready[i]     = 1'b0;
        reload[i]    = '0;
        countdown[i] = '0;
      end
      run_en     = 1'b1;
      mismatches = 0;
    endfunction

    function void set_run_enable(bit v);
      run_en = v;
    endfunction

    function int pending();
      return due_results.size();
    endfunction

    function out_item_t result(kind_t k, status_t s, int slot, bit disp, bit fin);
      out_item_t r;
      r.done_kind  = k;
      r.status     = s;
      r.slot       = SLOT_W'(slot);
      r.dispatched = disp;
      r.last       = fin;
      return r;
    endfunction

    function void report(string what, out_item_t want, out_item_t got);
      if (mismatches < 10)
        $display({"%0t: %s: expected kind=%0d status=%0d slot=%0d disp=%0b last=%0b,",
                  " got kind=%0d status=%0d slot=%0d disp=%0b last=%0b"},
                 $time, what, want.done_kind, want.status, want.slot, want.dispatched,
                 want.last, got.done_kind, got.status, got.slot, got.dispatched, got.last);
      mismatches++;
    endfunction

    function void accept_command(in_item_t cmd);
      bit [PERIOD_BITS_DEF-1:0] p;
      int                       free_slot;
      int                       last_ready;
      p = cmd.period[PERIOD_BITS_DEF-1:0];
      case (cmd.kind)
        KIND_REG: begin
          free_slot = -1;
          for (int i = SLOTS_DEF - 1; i >= 0; i--)
            if (!used[i]) free_slot = i;
          if (free_slot < 0) begin
            due_results.push_back(result(KIND_REG, STAT_FULL, 0, 1'b0, 1'b1));
          end else begin
            used[free_slot]      = 1'b1;
            reload[free_slot]    = p;
            countdown[free_slot] = p;
            ready[free_slot]     = 1'b0;
            due_results.push_back(result(KIND_REG, STAT_OK, free_slot, 1'b0, 1'b1));
          end
        end
        KIND_TICK: begin
          // A zero countdown holds: a zero period never fires.
          for (int i = 0; i < SLOTS_DEF; i++)
            if (used[i] && countdown[i] != 0) begin
              countdown[i]--;
              if (countdown[i] == 0) ready[i] = 1'b1;
            end
        end
        KIND_RUN: begin
          if (!run_en) begin
            due_results.push_back(result(KIND_RUN, STAT_DISABLED, 0, 1'b0, 1'b1));
          end else begin
            last_ready = -1;
            for (int i = 0; i < SLOTS_DEF; i++)
              if (used[i] && ready[i]) last_ready = i;
            if (last_ready < 0)
              due_results.push_back(result(KIND_RUN, STAT_OK, 0, 1'b0, 1'b1));
            for (int i = 0; i < SLOTS_DEF; i++)
              if (used[i] && ready[i]) begin
                due_results.push_back(result(KIND_RUN, STAT_OK, i, 1'b1, i == last_ready));
                countdown[i] = reload[i];
                ready[i]     = 1'b0;
              end
          end
        end
        default: ;  // unused kind: dropped without a trace
      endcase
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (due_results.size() == 0) begin
        report("result with nothing pending", '0, got);
        return;
      end
      want = due_results.pop_front();
      if (got.done_kind !== want.done_kind || got.status !== want.status ||
          got.slot !== want.slot || got.dispatched !== want.dispatched ||
          got.last !== want.last)
        report("result mismatch", want, got);
    endfunction

    function void flag_leftovers();
      while (due_results.size() != 0)
        report("result never arrived", due_results.pop_front(), '0);
    endfunction
  endclass

  logic      clk = 1'b0;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_item;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_item;
  logic      cfg_wr_en;
  logic      cfg_wr_data;

  dispatch_predictor predictor;

  int burst_left;
  int idle_cycles;
  int stall_mode;
  int stall_count;

  periodic_task_tick_scheduler uut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_item     (in_item),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_item    (out_item),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Sample both channels at the edge; every input is driven by nonblocking
  // assignment, so these are the values the block saw at this edge.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) predictor.accept_command(in_item);
      if (out_valid && !out_stall) predictor.check_result(out_item);
    end
  end

  // Receiver back-pressure: switch between a few stall patterns, including
  // long stretches with no stall at all.
  always @(posedge clk) begin
    if (stall_count == 0) begin
      stall_mode  <= $urandom_range(0, 3);
      stall_count <= $urandom_range(40, 160);
    end else begin
      stall_count <= stall_count - 1;
    end
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= 1'($urandom_range(0, 1));
      2: out_stall <= (stall_count % 4) != 0;   // mostly stalled
      default: out_stall <= ($urandom_range(0, 7) == 0);
    endcase
  end

  // Hang detector: count edges where nothing moves.
  always @(posedge clk) begin
    if (!rst_n || cfg_wr_en || (in_valid && !in_stall) || (out_valid && !out_stall))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  function automatic in_item_t command(kind_t k, logic [IN_PERIOD_W-1:0] p);
    in_item_t c;
    c.kind   = k;
    c.period = p;
    return c;
  endfunction

  // Mostly ticks and runs so the countdowns actually expire; register beats
  // keep probing the full table, and the unused kind shows up as noise.
  function automatic in_item_t random_command();
    int       pick;
    kind_t    k;
    pick = $urandom_range(0, 99);
    if (pick < 55)      k = KIND_TICK;
    else if (pick < 85) k = KIND_RUN;
    else if (pick < 93) k = KIND_REG;
    else                k = KIND_NONE;
    return command(k, IN_PERIOD_W'($urandom_range(0, 65535)));
  endfunction

  // Present one command and hold it until accepted; then either keep valid
  // up for the next beat of the burst or drop it for a random gap.
  task automatic send(in_item_t cmd);
    int gap;
    in_valid <= 1'b1;
    in_item  <= cmd;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    burst_left--;
    if (burst_left <= 0) begin
      gap = $urandom_range(0, 5);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? 40 : $urandom_range(1, 10);
    end
  endtask

  // Hold off the sender until every pending result is back, then give a
  // trailing tick time to leave the ring.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (predictor.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_run_enable(bit v);
    drain();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    predictor.set_run_enable(v);
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  task automatic random_phase(int n);
    in_item_t c;
    int       counted;
    counted = 0;
    while (counted < n) begin
      c = random_command();
      send(c);
      if (c.kind != KIND_NONE) counted++;
    end
  endtask

  initial begin
    predictor   = new();
    burst_left  = 4;
    idle_cycles = 0;
    stall_mode  = 0;
    stall_count = 0;
    rst_n       <= 1'b0;
    in_valid    <= 1'b0;
    in_item     <= '0;
    out_stall   <= 1'b0;
    cfg_wr_en   <= 1'b0;
    cfg_wr_data <= 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    write_run_enable(1'b1);

    // Directed: empty table, the unused kind, then a table built up so that
    // one run dispatches several slots, and finally a full table.
    send(command(KIND_RUN,  16'h0000));   // nothing ready
    send(command(KIND_NONE, 16'h5A5A));   // dropped
    send(command(KIND_TICK, 16'hFFFF));   // tick on an empty table
    send(command(KIND_REG,  16'd1));      // slot 0
    send(command(KIND_TICK, 16'h0000));
    send(command(KIND_RUN,  16'h0000));   // dispatch slot 0 alone
    send(command(KIND_REG,  16'd0));      // zero period: never fires
    send(command(KIND_REG,  16'hFFFF));   // widest period
    send(command(KIND_REG,  16'd2));
    send(command(KIND_REG,  16'd1));
    send(command(KIND_TICK, 16'h0000));
    send(command(KIND_TICK, 16'h0000));
    send(command(KIND_RUN,  16'h0000));   // several slots, last on the highest
    send(command(KIND_REG,  16'd3));
    send(command(KIND_REG,  16'd1));
    send(command(KIND_REG,  16'd4));      // table now full
    send(command(KIND_REG,  16'hA5A5));   // rejected: full
    send(command(KIND_TICK, 16'h0000));

    // Runs while disabled leave the table alone.
    write_run_enable(1'b0);
    send(command(KIND_RUN,  16'h0000));
    send(command(KIND_TICK, 16'h0000));
    send(command(KIND_RUN,  16'hFFFF));

    write_run_enable(1'b1);
    send(command(KIND_RUN,  16'h0000));   // everything held back comes out now
    send(command(KIND_NONE, 16'hFFFF));

    random_phase(60);
    write_run_enable(1'b0);
    random_phase(50);
    write_run_enable(1'b1);
    random_phase(60);

    drain();
    predictor.flag_leftovers();
    if (predictor.mismatches == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule

### filelist.f
rtl/core/ptts_pkg.sv
rtl/core/ptts_cell.sv
rtl/core/ptts_head.sv
rtl/core/periodic_task_tick_scheduler.sv
tb/periodic_task_tick_scheduler_tb.sv
